/* rtl/wwr_pkg.sv */
// ----------------------------------------------------------------------------
// wwr_pkg
// shared constants, codes and types of the whole word replacer
// ----------------------------------------------------------------------------
`default_nettype none

package wwr_pkg;

    // default longest pattern / replacement, in bytes
    localparam int MAX_WORD_DEF = 8;

    // word separator
    localparam logic [7:0] SPACE_CHAR = 8'd32;

    // request op codes
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_END  = 1'b1;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PATTERN_TEXT     = 2'd0;
    localparam t_cfg_idx CFG_PATTERN_LEN      = 2'd1;
    localparam t_cfg_idx CFG_REPLACEMENT_TEXT = 2'd2;
    localparam t_cfg_idx CFG_REPLACEMENT_LEN  = 2'd3;

    // control from the word engine to the output serializer
    typedef struct packed {
        logic load;
        logic has_char;
        logic end_of_text;
    } t_burst_ctl;

endpackage

`default_nettype wire

/* rtl/whole_word_replacer_top.sv */
// ----------------------------------------------------------------------------
// whole_word_replacer_top
// replaces every space separated word equal to a pattern by a replacement
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  input     i_valid / o_ready, i_op, i_in_char        request in
//  output    o_valid / i_ready, o_out_char, o_has_char,
//            o_last_of_run, o_end_of_text              request out
//  config    i_cfg_valid / o_cfg_ready, i_cfg_index,
//            i_cfg_data                                register write in
//
//  a text byte buffered into the current word gives no result; a request
//  with k results, k from 1 to MAX_WORD+1, holds the input until the
//  last result is taken; the output register sends one byte per cycle
//  while i_ready is high; the next request is taken in the cycle the
//  last result of the previous one is taken, so a full output side sees
//  no bubble; reset is synchronous, active low, and clears the word
//  state and all configuration registers and empties the output register;
//  there is no clearing pass; the configuration port is always ready
// ----------------------------------------------------------------------------
`default_nettype none

module whole_word_replacer_top #(
    parameter int MAX_WORD = wwr_pkg::MAX_WORD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // text input
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_op,
    input  wire logic [7:0]        i_in_char,
    // result output
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [7:0]        o_out_char,
    output logic                   o_has_char,
    output logic                   o_last_of_run,
    output logic                   o_end_of_text,
    // configuration writes
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire wwr_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [63:0]       i_cfg_data
);
    import wwr_pkg::*;

    localparam int CW = $clog2(MAX_WORD + 2);

    // configuration registers
    logic [63:0] r_pattern_text, r_replacement_text;
    logic [3:0]  r_pattern_len, r_replacement_len;

    // burst from the word engine into the result register
    t_burst_ctl                burst_ctl;
    logic [CW-1:0]             burst_count;
    logic [8*(MAX_WORD+1)-1:0] burst_bytes;
    logic                      emit_free;
    logic                      accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = emit_free;
    assign accept      = i_valid && emit_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_text     <= '0;
            r_pattern_len      <= '0;
            r_replacement_text <= '0;
            r_replacement_len  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_TEXT:     r_pattern_text     <= i_cfg_data;
                CFG_PATTERN_LEN:      r_pattern_len      <= i_cfg_data[3:0];
                CFG_REPLACEMENT_TEXT: r_replacement_text <= i_cfg_data;
                CFG_REPLACEMENT_LEN:  r_replacement_len  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // word buffer, match and burst build
    wwr_core #(
        .MAX_WORD (MAX_WORD)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_op               (i_op),
        .i_in_char          (i_in_char),
        .i_pattern_text     (r_pattern_text),
        .i_pattern_len      (r_pattern_len),
        .i_replacement_text (r_replacement_text),
        .i_replacement_len  (r_replacement_len),
        .o_ctl              (burst_ctl),
        .o_count            (burst_count),
        .o_bytes            (burst_bytes)
    );

    // result register, one byte per cycle while i_ready is high
    wwr_emit #(
        .MAX_WORD (MAX_WORD)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (burst_ctl),
        .i_count       (burst_count),
        .i_bytes       (burst_bytes),
        .o_free        (emit_free),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_has_char    (o_has_char),
        .o_last_of_run (o_last_of_run),
        .o_end_of_text (o_end_of_text)
    );

endmodule

`default_nettype wire

/* rtl/wwr_core.sv */
// ----------------------------------------------------------------------------
// wwr_core
// word state and single pass burst build for one accepted request
// ----------------------------------------------------------------------------
`default_nettype none

module wwr_core #(
    parameter int  MAX_WORD = wwr_pkg::MAX_WORD_DEF,
    localparam int LW       = $clog2(MAX_WORD + 1),
    localparam int CW       = $clog2(MAX_WORD + 2)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic                      i_op,
    input  wire logic [7:0]                i_in_char,
    input  wire logic [63:0]               i_pattern_text,
    input  wire logic [3:0]                i_pattern_len,
    input  wire logic [63:0]               i_replacement_text,
    input  wire logic [3:0]                i_replacement_len,
    output wwr_pkg::t_burst_ctl            o_ctl,
    output logic      [CW-1:0]             o_count,
    output logic      [8*(MAX_WORD+1)-1:0] o_bytes
);
    import wwr_pkg::*;

    localparam logic [3:0] MAX_L = 4'(MAX_WORD);

    logic [7:0]    r_buf [MAX_WORD];
    logic [LW-1:0] r_wlen, n_wlen;
    logic          r_pass, n_pass;

    logic [LW-1:0] plen, rlen;
    logic          match;
    logic          is_end, word_end, grow, use_rep, empty, app;
    logic [CW-1:0] flush_n, n0;
    logic [7:0]    c_eff;

    // lengths above the buffer depth saturate
    assign plen = LW'((i_pattern_len > MAX_L) ? MAX_L : i_pattern_len);
    assign rlen = LW'((i_replacement_len > MAX_L) ? MAX_L : i_replacement_len);

    always_comb begin
        match = (r_wlen == plen);
        for (int i = 0; i < MAX_WORD; i++) begin
            if (LW'(i) < plen && r_buf[i] != i_pattern_text[8*i +: 8]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        is_end   = (i_op == OP_END);
        word_end = is_end || (i_in_char == SPACE_CHAR);
        grow     = !word_end && !r_pass && (r_wlen < plen);
        use_rep  = word_end && !r_pass && match;
        flush_n  = use_rep ? CW'(rlen) : CW'(r_wlen);
        n0       = r_pass ? '0 : flush_n;
        empty    = (n0 == '0);
        app      = is_end ? empty : 1'b1;
        c_eff    = is_end ? 8'd0 : i_in_char;

        o_count           = n0 + CW'(app);
        o_ctl.load        = i_accept && !grow;
        o_ctl.has_char    = !(is_end && empty);
        o_ctl.end_of_text = is_end;

        // word bytes first, then the trailing byte
        for (int i = 0; i <= MAX_WORD; i++) begin
            o_bytes[8*i +: 8] = c_eff;
            if (i < MAX_WORD && CW'(i) < n0) begin
                o_bytes[8*i +: 8] = use_rep ? i_replacement_text[8*i +: 8] : r_buf[i];
            end
        end

        n_wlen = r_wlen;
        n_pass = r_pass;
        if (word_end) begin
            n_wlen = '0;
            n_pass = 1'b0;
        end else if (!r_pass) begin
            if (grow) begin
                n_wlen = r_wlen + LW'(1);
            end else begin
                n_wlen = '0;
                n_pass = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= '0;
            r_pass <= 1'b0;
        end else if (i_accept) begin
            r_wlen <= n_wlen;
            r_pass <= n_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_WORD; i++) begin
            if (i_accept && grow && r_wlen == LW'(i)) begin
                r_buf[i] <= i_in_char;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/wwr_emit.sv */
// ----------------------------------------------------------------------------
// wwr_emit
// result register that sends a loaded burst one byte per cycle while i_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module wwr_emit #(
    parameter int  MAX_WORD = wwr_pkg::MAX_WORD_DEF,
    localparam int CW       = $clog2(MAX_WORD + 2)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire wwr_pkg::t_burst_ctl       i_ctl,
    input  wire logic [CW-1:0]             i_count,
    input  wire logic [8*(MAX_WORD+1)-1:0] i_bytes,
    output logic                           o_free,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic      [7:0]                o_out_char,
    output logic                           o_has_char,
    output logic                           o_last_of_run,
    output logic                           o_end_of_text
);
    import wwr_pkg::*;

    logic [8*(MAX_WORD+1)-1:0] r_bytes;
    logic [CW-1:0]             r_left;
    logic                      r_has, r_eot, r_busy;
    logic                      pop, last;

    assign last   = (r_left == CW'(1));
    assign pop    = r_busy && i_ready;
    assign o_free = !r_busy || (pop && last);

    assign o_valid       = r_busy;
    assign o_out_char    = r_bytes[7:0];
    assign o_has_char    = r_has;
    assign o_last_of_run = last;
    assign o_end_of_text = r_eot && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
            r_left <= i_count;
        end else if (pop) begin
            r_left <= r_left - CW'(1);
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bytes <= i_bytes;
            r_has   <= i_ctl.has_char;
            r_eot   <= i_ctl.end_of_text;
        end else if (pop) begin
            r_bytes <= r_bytes >> 8;
        end
    end

endmodule

`default_nettype wire

/* rtl/wwr_checker.sv */
// ----------------------------------------------------------------------------
// wwr_checker
// port level checks of the whole word replacer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wwr_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [7:0]        o_out_char,
    input wire logic              o_has_char,
    input wire logic              o_last_of_run,
    input wire logic              o_end_of_text
);

    // a pending result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // input is taken only when the result register empties
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || (i_ready && o_last_of_run)))
        else $error("input ready out of step with result register");

    // end of text closes the run
    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_text |-> o_last_of_run)
        else $error("end of text not on last result");

    // empty marker only at end of text, with a zero byte
    a_empty_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_char |-> o_end_of_text && o_out_char == 8'd0)
        else $error("empty result outside end of text");

    // reset empties the result register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind whole_word_replacer_top wwr_checker u_wwr_checker (.*);

`default_nettype wire
